FILE: hw/rtl/fcw_pkg.sv
// Shared types, codes and constants for the FAT12 chain sector walker.
// No dependencies; every file but fcw_table refers to it by scoped names.
package fcw_pkg;

  localparam int CLUSTER_W = 12;
  localparam int SIZE_W    = 32;
  localparam int SECTOR_W  = 13;
  localparam int COUNT_W   = 10;
  localparam int OFFSET_W  = 13;
  localparam int BIAS_W    = 8;

  localparam logic [CLUSTER_W-1:0] EOC_MIN    = 12'hFF8;
  localparam logic [CLUSTER_W-1:0] BAD_MARK   = 12'hFF7;
  localparam logic [CLUSTER_W-1:0] FIRST_DATA = 12'd2;
  localparam logic [BIAS_W-1:0]    BIAS_RESET = 8'd31;
  localparam logic [7:0]           LO_NIB     = 8'h0F;
  localparam logic [7:0]           HI_NIB     = 8'hF0;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_START   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOCHAIN = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_RD0,
    S_RD1,
    S_RD2,
    S_CNT,
    S_SEC
  } state_t;

  typedef enum logic [1:0] {
    ALU_OFF3,
    ALU_INC,
    ALU_SUBSEC,
    ALU_SECT
  } alu_op_t;

  function automatic logic [CLUSTER_W-1:0] unpack_entry(
    input logic [7:0] lo,
    input logic [7:0] hi,
    input logic       odd
  );
    logic [CLUSTER_W-1:0] ent;
    if (odd) begin
      ent = {hi, 4'((lo & HI_NIB) >> 4)};
    end else begin
      ent = {4'(hi & LO_NIB), lo};
    end
    return ent;
  endfunction

endpackage

FILE: hw/rtl/fat12_chain_sector_walker_core.sv
// Top level of the FAT12 chain sector walker: table store, sequencer and
// shared adder. Depends on fcw_pkg, fcw_table, fcw_alu and fcw_seq.
//
// Load the allocation table one byte per item (operation 0), then start a
// chain (operation 1) and step it (operation 2). Every item gives exactly
// one result, presented for a single cycle with done high; the receiver
// cannot stall, so sample on done. busy is high while an item is in work.
// A load, an advance with no chain, a zero-size start or an unused code
// gives its result in the cycle after it is taken. A start checks the
// cluster, ending there if it is bad, reads its entry to detect end of
// chain and forms the byte count and sector; an advance first reads the
// current entry to find the next cluster, then goes on as a start does. The
// single-port table store makes each entry cost two byte reads; one shared
// adder forms offsets, byte count and sector number. The user must write
// sector_bias via cfg_we/cfg_wdata while idle; block does not enforce it.
module fat12_chain_sector_walker_core #(
  parameter int TABLE_BYTES  = 6144,
  parameter int SECTOR_BYTES = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      operation,
  input  logic [12:0]                     table_offset,
  input  logic [7:0]                      table_byte,
  input  logic [fcw_pkg::CLUSTER_W-1:0]   first_cluster,
  input  logic [fcw_pkg::SIZE_W-1:0]      file_size,
  input  logic                            cfg_we,
  input  logic [fcw_pkg::BIAS_W-1:0]      cfg_wdata,
  output logic                            done,
  output logic [fcw_pkg::SECTOR_W-1:0]    sector,
  output logic [fcw_pkg::COUNT_W-1:0]     byte_count,
  output logic                            last,
  output logic [1:0]                      status
);

  localparam int AW = $clog2(TABLE_BYTES);

  fcw_pkg::alu_op_t                alu_op;
  logic [fcw_pkg::CLUSTER_W-1:0]   alu_cur;
  logic [fcw_pkg::OFFSET_W-1:0]    alu_off;
  logic [fcw_pkg::SIZE_W-1:0]      alu_rem;
  logic [fcw_pkg::BIAS_W-1:0]      alu_bias;
  logic [fcw_pkg::SIZE_W:0]        alu_sum;
  logic                            mem_we;
  logic [AW-1:0]                   mem_addr;
  logic [7:0]                      mem_wdata;
  logic [7:0]                      mem_rdata;

  fcw_table #(
    .DEPTH (TABLE_BYTES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fcw_alu #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_alu (
    .op   (alu_op),
    .cur  (alu_cur),
    .off  (alu_off),
    .rem  (alu_rem),
    .bias (alu_bias),
    .sum  (alu_sum)
  );

  fcw_seq #(
    .TABLE_BYTES  (TABLE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .AW           (AW)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .table_offset  (table_offset),
    .table_byte    (table_byte),
    .first_cluster (first_cluster),
    .file_size     (file_size),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .alu_op        (alu_op),
    .alu_cur       (alu_cur),
    .alu_off       (alu_off),
    .alu_rem       (alu_rem),
    .alu_bias      (alu_bias),
    .alu_sum       (alu_sum),
    .mem_we        (mem_we),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .mem_rdata     (mem_rdata),
    .done          (done),
    .sector        (sector),
    .byte_count    (byte_count),
    .last          (last),
    .status        (status)
  );

endmodule

FILE: hw/rtl/fcw_table.sv
// Single-port allocation table store with registered read data.
// Uses no package items.
module fcw_table #(
  parameter int DEPTH = 6144,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hw/rtl/fcw_alu.sv
// Shared adder for the walker: entry offset, address increment,
// sector count subtract and sector number. Depends on fcw_pkg.
module fcw_alu #(
  parameter int SECTOR_BYTES = 512
) (
  input  fcw_pkg::alu_op_t                    op,
  input  logic [fcw_pkg::CLUSTER_W-1:0]       cur,
  input  logic [fcw_pkg::OFFSET_W-1:0]        off,
  input  logic [fcw_pkg::SIZE_W-1:0]          rem,
  input  logic [fcw_pkg::BIAS_W-1:0]          bias,
  output logic [fcw_pkg::SIZE_W:0]            sum
);

  logic [fcw_pkg::SIZE_W-1:0] a;
  logic [fcw_pkg::SIZE_W-1:0] b;
  logic                       cin;

  always_comb begin
    a   = '0;
    b   = '0;
    cin = 1'b0;
    case (op)
      fcw_pkg::ALU_OFF3: begin
        a = fcw_pkg::SIZE_W'(cur);
        b = fcw_pkg::SIZE_W'({cur, 1'b0});
      end
      fcw_pkg::ALU_INC: begin
        a   = fcw_pkg::SIZE_W'(off);
        cin = 1'b1;
      end
      fcw_pkg::ALU_SUBSEC: begin
        a   = rem;
        b   = ~fcw_pkg::SIZE_W'(SECTOR_BYTES);
        cin = 1'b1;
      end
      fcw_pkg::ALU_SECT: begin
        a = fcw_pkg::SIZE_W'(bias);
        b = fcw_pkg::SIZE_W'(cur);
      end
      default: begin
        a = '0;
      end
    endcase
    sum = {1'b0, a} + {1'b0, b} + (fcw_pkg::SIZE_W + 1)'(cin);
  end

endmodule

FILE: hw/rtl/fcw_seq.sv
// Sequencer and chain state of the walker: decodes items, steps table
// reads, drives the shared adder and forms results. Depends on fcw_pkg.
module fcw_seq #(
  parameter int TABLE_BYTES  = 6144,
  parameter int SECTOR_BYTES = 512,
  parameter int AW           = 13
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      operation,
  input  logic [12:0]                     table_offset,
  input  logic [7:0]                      table_byte,
  input  logic [fcw_pkg::CLUSTER_W-1:0]   first_cluster,
  input  logic [fcw_pkg::SIZE_W-1:0]      file_size,
  input  logic                            cfg_we,
  input  logic [fcw_pkg::BIAS_W-1:0]      cfg_wdata,
  output fcw_pkg::alu_op_t                alu_op,
  output logic [fcw_pkg::CLUSTER_W-1:0]   alu_cur,
  output logic [fcw_pkg::OFFSET_W-1:0]    alu_off,
  output logic [fcw_pkg::SIZE_W-1:0]      alu_rem,
  output logic [fcw_pkg::BIAS_W-1:0]      alu_bias,
  input  logic [fcw_pkg::SIZE_W:0]        alu_sum,
  output logic                            mem_we,
  output logic [AW-1:0]                   mem_addr,
  output logic [7:0]                      mem_wdata,
  input  logic [7:0]                      mem_rdata,
  output logic                            done,
  output logic [fcw_pkg::SECTOR_W-1:0]    sector,
  output logic [fcw_pkg::COUNT_W-1:0]     byte_count,
  output logic                            last,
  output logic [1:0]                      status
);

  fcw_pkg::state_t                 state, state_next;
  logic                            follow, follow_next;
  logic [fcw_pkg::CLUSTER_W-1:0]   cur, cur_next;
  logic [fcw_pkg::SIZE_W-1:0]      rem, rem_next;
  logic                            active, active_next;
  logic [fcw_pkg::BIAS_W-1:0]      bias;
  logic [fcw_pkg::OFFSET_W-1:0]    off, off_next;
  logic [7:0]                      lo, lo_next;
  logic [fcw_pkg::CLUSTER_W-1:0]   entry, entry_next;
  logic                            done_next;
  logic [fcw_pkg::SECTOR_W-1:0]    sector_next;
  logic [fcw_pkg::COUNT_W-1:0]     byte_count_next;
  logic                            last_next;
  logic [1:0]                      status_next;

  logic [fcw_pkg::OFFSET_W-1:0]    off_calc;
  logic                            bad;
  logic [fcw_pkg::CLUSTER_W-1:0]   ent_calc;
  logic [fcw_pkg::SIZE_W-1:0]      cnt_calc;
  logic [fcw_pkg::SIZE_W-1:0]      rem_calc;

  assign busy      = (state != fcw_pkg::S_IDLE);
  assign alu_cur   = cur;
  assign alu_off   = off;
  assign alu_rem   = rem;
  assign alu_bias  = bias;
  assign mem_wdata = table_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fcw_pkg::S_IDLE;
      active <= 1'b0;
      cur    <= '0;
      rem    <= '0;
      follow <= 1'b0;
      done   <= 1'b0;
      bias   <= fcw_pkg::BIAS_RESET;
    end else begin
      state  <= state_next;
      active <= active_next;
      cur    <= cur_next;
      rem    <= rem_next;
      follow <= follow_next;
      done   <= done_next;
      if (cfg_we) begin
        bias <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    off        <= off_next;
    lo         <= lo_next;
    entry      <= entry_next;
    sector     <= sector_next;
    byte_count <= byte_count_next;
    last       <= last_next;
    status     <= status_next;
  end

  always_comb begin
    state_next      = state;
    follow_next     = follow;
    cur_next        = cur;
    rem_next        = rem;
    active_next     = active;
    off_next        = off;
    lo_next         = lo;
    entry_next      = entry;
    done_next       = 1'b0;
    sector_next     = sector;
    byte_count_next = byte_count;
    last_next       = last;
    status_next     = status;
    alu_op          = fcw_pkg::ALU_OFF3;
    mem_we          = 1'b0;
    mem_addr        = table_offset[AW-1:0];

    off_calc = alu_sum[fcw_pkg::OFFSET_W:1];
    bad      = (cur < fcw_pkg::FIRST_DATA) || (cur == fcw_pkg::BAD_MARK) ||
               (cur >= fcw_pkg::EOC_MIN) ||
               !(off_calc < fcw_pkg::OFFSET_W'(TABLE_BYTES - 1));
    ent_calc = fcw_pkg::unpack_entry(lo, mem_rdata, cur[0]);
    cnt_calc = alu_sum[fcw_pkg::SIZE_W] ? fcw_pkg::SIZE_W'(SECTOR_BYTES) : rem;
    rem_calc = alu_sum[fcw_pkg::SIZE_W] ? alu_sum[fcw_pkg::SIZE_W-1:0] : '0;

    case (state)
      fcw_pkg::S_IDLE: begin
        if (start) begin
          sector_next     = '0;
          byte_count_next = '0;
          last_next       = 1'b0;
          status_next     = fcw_pkg::ST_OK;
          case (operation)
            fcw_pkg::OP_LOAD: begin
              mem_we    = (table_offset < 13'(TABLE_BYTES));
              done_next = 1'b1;
            end
            fcw_pkg::OP_START: begin
              active_next = 1'b0;
              cur_next    = first_cluster;
              rem_next    = file_size;
              if (file_size == '0) begin
                last_next = 1'b1;
                done_next = 1'b1;
              end else begin
                follow_next = 1'b0;
                state_next  = fcw_pkg::S_CHK;
              end
            end
            fcw_pkg::OP_ADVANCE: begin
              if (!active) begin
                status_next = fcw_pkg::ST_NOCHAIN;
                done_next   = 1'b1;
              end else begin
                follow_next = 1'b1;
                state_next  = fcw_pkg::S_CHK;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      fcw_pkg::S_CHK: begin
        alu_op   = fcw_pkg::ALU_OFF3;
        off_next = off_calc;
        if (bad) begin
          active_next     = 1'b0;
          sector_next     = '0;
          byte_count_next = '0;
          last_next       = 1'b0;
          status_next     = fcw_pkg::ST_BAD;
          done_next       = 1'b1;
          state_next      = fcw_pkg::S_IDLE;
        end else begin
          state_next = fcw_pkg::S_RD0;
        end
      end
      fcw_pkg::S_RD0: begin
        mem_addr   = off[AW-1:0];
        state_next = fcw_pkg::S_RD1;
      end
      fcw_pkg::S_RD1: begin
        alu_op     = fcw_pkg::ALU_INC;
        mem_addr   = alu_sum[AW-1:0];
        lo_next    = mem_rdata;
        state_next = fcw_pkg::S_RD2;
      end
      fcw_pkg::S_RD2: begin
        entry_next = ent_calc;
        if (follow) begin
          cur_next    = ent_calc;
          follow_next = 1'b0;
          state_next  = fcw_pkg::S_CHK;
        end else begin
          state_next = fcw_pkg::S_CNT;
        end
      end
      fcw_pkg::S_CNT: begin
        alu_op          = fcw_pkg::ALU_SUBSEC;
        rem_next        = rem_calc;
        byte_count_next = cnt_calc[fcw_pkg::COUNT_W-1:0];
        last_next       = (rem_calc == '0) || (entry >= fcw_pkg::EOC_MIN);
        state_next      = fcw_pkg::S_SEC;
      end
      fcw_pkg::S_SEC: begin
        alu_op      = fcw_pkg::ALU_SECT;
        sector_next = alu_sum[fcw_pkg::SECTOR_W-1:0];
        status_next = fcw_pkg::ST_OK;
        active_next = !last;
        done_next   = 1'b1;
        state_next  = fcw_pkg::S_IDLE;
      end
      default: begin
        state_next = fcw_pkg::S_IDLE;
      end
    endcase
  end

endmodule
